FILE: sv/i2bs_pkg.sv
// ----------------------------------------------------------------------------
// i2bs_pkg
// Shared types, character codes and the digit-to-character mapping for the
// integer to base string converter.
// ----------------------------------------------------------------------------
package i2bs_pkg;

  localparam int REG_W  = 6;
  localparam int CHAR_W = 7;

  localparam logic [REG_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [REG_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [REG_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [REG_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 7'h57;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS     = 7'h2d;

  typedef struct packed {
    logic             neg;
    logic [REG_W-1:0] base;
    logic [REG_W-1:0] width;
  } job_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REG_W-1:0] d);
    if (d < DEC_DIGITS) begin
      return CH_ZERO + {1'b0, d};
    end
    return CH_ALPHA_OFS + {1'b0, d};
  endfunction

endpackage

FILE: sv/i2bs_front.sv
// ----------------------------------------------------------------------------
// i2bs_front
// Holds the configuration registers, accepts items and classifies each value
// into sign and magnitude before handing the job to the queue.
// ----------------------------------------------------------------------------
module i2bs_front #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_CHARS  = 33
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [i2bs_pkg::REG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [VALUE_BITS-1:0]        q_mag,
  output i2bs_pkg::job_ctl_t           q_ctl
);

  localparam logic REG_RADIX     = 1'b0;
  localparam logic REG_MIN_WIDTH = 1'b1;
  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

  logic [i2bs_pkg::REG_W-1:0] radix_r, radix_nxt;
  logic [i2bs_pkg::REG_W-1:0] min_width_r, min_width_nxt;
  logic                       neg;

  always_comb begin
    radix_nxt     = radix_r;
    min_width_nxt = min_width_r;
    if (cfg_index == REG_RADIX) begin
      if (cfg_wdata < i2bs_pkg::RADIX_MIN) begin
        radix_nxt = i2bs_pkg::RADIX_MIN;
      end else if (cfg_wdata > i2bs_pkg::RADIX_MAX) begin
        radix_nxt = i2bs_pkg::RADIX_MAX;
      end else begin
        radix_nxt = cfg_wdata;
      end
    end
    if (cfg_index == REG_MIN_WIDTH) begin
      if ({1'b0, cfg_wdata} > 7'(MAX_CHARS)) begin
        min_width_nxt = i2bs_pkg::REG_W'(MAX_CHARS);
      end else begin
        min_width_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= i2bs_pkg::RADIX_RESET;
      min_width_r <= '0;
    end else if (cfg_wr_en) begin
      radix_r     <= radix_nxt;
      min_width_r <= min_width_nxt;
    end
  end

  assign neg      = in_value[VALUE_BITS-1];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_mag    = neg ? (~in_value) + ONE : in_value;

  always_comb begin
    q_ctl.neg   = neg;
    q_ctl.base  = radix_r;
    q_ctl.width = min_width_r;
  end

endmodule

FILE: sv/i2bs_fifo.sv
// ----------------------------------------------------------------------------
// i2bs_fifo
// Two-entry job queue between the classifying front and the conversion back.
// ----------------------------------------------------------------------------
module i2bs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("Queue written while full.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("Queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH))
    else $error("Queue count out of range.");

endmodule

FILE: sv/i2bs_back.sv
// ----------------------------------------------------------------------------
// i2bs_back
// Converts one queued job: repeated division by the base, eight quotient bits
// per cycle, digits kept in a small store, then padding, sign and digits are
// emitted via an output register at one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2bs_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  logic [VALUE_BITS-1:0]            q_mag,
  input  i2bs_pkg::job_ctl_t               q_ctl,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [i2bs_pkg::CHAR_W-1:0]      out_char,
  output logic                             out_last
);

  localparam int DIV_BITS = 8;
  localparam int STEPS    = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QW       = STEPS * DIV_BITS;
  localparam int SW       = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CW       = $clog2(VALUE_BITS + 1);
  localparam int AW       = $clog2(VALUE_BITS);
  localparam int TW       = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int RW       = i2bs_pkg::REG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PREP, ST_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic [QW-1:0]                quot_r, quot_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [SW-1:0]                step_r, step_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  i2bs_pkg::job_ctl_t           ctl_r, ctl_nxt;
  logic [TW-1:0]                pad_r, pad_nxt;
  logic                         neg_r, neg_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [i2bs_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [RW-1:0]                digit_mem [VALUE_BITS];
  logic [RW-1:0]                mem_q_r;
  logic                         mem_we;
  logic [CW-1:0]                rd_sel;
  logic [AW-1:0]                rd_addr;

  logic [RW:0]                  div_trial;
  logic [RW-1:0]                div_rem;
  logic [DIV_BITS-1:0]          div_qb;
  logic [QW-1:0]                div_quot;
  logic                         last_step;
  logic [TW-1:0]                text_len;
  logic [TW-1:0]                width_ext;
  logic                         load;

  always_comb begin
    div_rem   = rem_r;
    div_qb    = '0;
    div_trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_trial = {div_rem, quot_r[QW-1-i]};
      if (div_trial >= {1'b0, ctl_r.base}) begin
        div_trial            = div_trial - {1'b0, ctl_r.base};
        div_qb[DIV_BITS-1-i] = 1'b1;
      end
      div_rem = div_trial[RW-1:0];
    end
    div_quot = (quot_r << DIV_BITS) | QW'(div_qb);
  end

  assign last_step = (step_r == SW'(STEPS - 1));
  assign text_len  = TW'(cnt_r) + TW'(ctl_r.neg);
  assign width_ext = TW'(ctl_r.width);
  assign load      = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    ctl_nxt       = ctl_r;
    pad_nxt       = pad_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_sel        = idx_r - CW'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          quot_nxt  = QW'(q_mag);
          ctl_nxt   = q_ctl;
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_nxt = div_quot;
        if (last_step) begin
          mem_we   = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
          rem_nxt  = '0;
          step_nxt = '0;
          if (div_quot == '0) begin
            state_nxt = ST_PREP;
          end
        end else begin
          rem_nxt  = div_rem;
          step_nxt = step_r + SW'(1);
        end
      end
      ST_PREP: begin
        rd_sel    = cnt_r - CW'(1);
        pad_nxt   = (width_ext > text_len) ? width_ext - text_len : '0;
        neg_nxt   = ctl_r.neg;
        idx_nxt   = cnt_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (pad_r != '0) begin
            out_char_nxt = i2bs_pkg::CH_SPACE;
            out_last_nxt = 1'b0;
            pad_nxt      = pad_r - TW'(1);
          end else if (neg_r) begin
            out_char_nxt = i2bs_pkg::CH_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = i2bs_pkg::digit_char(mem_q_r);
            out_last_nxt = (idx_r == CW'(1));
            idx_nxt      = idx_r - CW'(1);
            rd_sel       = (idx_r > CW'(1)) ? idx_r - CW'(2) : '0;
            if (idx_r == CW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = rd_sel[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[AW-1:0]] <= div_rem;
    end
    mem_q_r <= digit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      pad_r       <= '0;
      neg_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      pad_r       <= pad_nxt;
      neg_r       <= neg_nxt;
      idx_r       <= idx_nxt;
    end
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    ctl_r      <= ctl_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < ctl_r.base))
    else $error("Partial remainder not below the base.");
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CW'(VALUE_BITS)))
    else $error("Digit store overflow.");
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r != '0))
    else $error("Emitting with no digit left.");

endmodule

FILE: sv/integer_to_base_string.sv
// ----------------------------------------------------------------------------
// integer_to_base_string
// Converts a signed integer into its ASCII text in a configurable base.
// ----------------------------------------------------------------------------
// Each item is a two's complement value; its text comes out one character per
// transfer, most significant first, left padded with spaces to min_width,
// with a minus sign for negative values and tlast on the final digit. Digits
// are produced by a divide unit that retires eight quotient bits per cycle; a
// load step precedes the division and a setup step follows it, after which
// the characters leave at one per cycle unless out_tready stalls them. A
// two-entry queue lets the next items be accepted while one is converted.
// Radix writes are clamped to 2..36 and min_width to MAX_CHARS.
// ----------------------------------------------------------------------------
module integer_to_base_string #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_CHARS  = 33
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [5:0]                         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // value [VALUE_BITS-1:0], zero fill above
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // char_out [6:0], zero fill [7]
  output logic [7:0]                         out_tdata,
  output logic                               out_tlast
);

  localparam int JOB_W = VALUE_BITS + $bits(i2bs_pkg::job_ctl_t);

  logic                          q_push, q_pop, q_full, q_empty;
  logic [VALUE_BITS-1:0]         front_mag, back_mag;
  i2bs_pkg::job_ctl_t            front_ctl, back_ctl;
  logic [JOB_W-1:0]              q_wdata, q_rdata;
  logic [i2bs_pkg::CHAR_W-1:0]   out_char;

  i2bs_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_mag    (front_mag),
    .q_ctl    (front_ctl)
  );

  assign q_wdata = {front_mag, front_ctl};

  i2bs_fifo #(
    .W(JOB_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  assign back_mag = q_rdata[JOB_W-1 -: VALUE_BITS];
  assign back_ctl = q_rdata[$bits(i2bs_pkg::job_ctl_t)-1:0];

  i2bs_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_mag    (back_mag),
    .q_ctl    (back_ctl),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_char (out_char),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule
